[design/lsae_pkg.sv]
// lsae_pkg: shared types, opcodes and helpers of the load/store alu execute unit
// no dependencies; imported by every module of the block

package lsae_pkg;

    localparam int REG_COUNT  = 16;
    localparam int REG_ADDR_W = $clog2(REG_COUNT);
    localparam int DATA_W     = 32;

    typedef enum logic [3:0] {
        OP_ADD         = 4'd0,
        OP_SUB         = 4'd1,
        OP_CMP         = 4'd2,
        OP_MOV         = 4'd3,
        OP_AND         = 4'd4,
        OP_OR          = 4'd5,
        OP_XOR         = 4'd6,
        OP_NOT         = 4'd7,
        OP_LOAD        = 4'd8,
        OP_STORE       = 4'd9,
        OP_LOAD_RETURN = 4'd10
    } op_t;

    typedef enum logic [1:0] {
        SIZE_BYTE = 2'd0,
        SIZE_HALF = 2'd1,
        SIZE_WORD = 2'd2,
        SIZE_RSVD = 2'd3
    } size_t;

    typedef struct packed {
        logic [3:0]            req_type;
        logic [REG_ADDR_W-1:0] dest_reg;
        logic [REG_ADDR_W-1:0] src_reg;
        logic                  ext_present;
        logic [DATA_W-1:0]     ext_imm;
        logic [1:0]            access_size;
        logic                  sign_extend;
        logic                  post_increment;
        logic [DATA_W-1:0]     load_data;
    } req_t;

    typedef struct packed {
        logic              bus_request;
        logic              bus_write;
        logic [DATA_W-1:0] bus_address;
        logic [1:0]        bus_size;
        logic [DATA_W-1:0] bus_write_data;
        logic [DATA_W-1:0] result_value;
        logic              flag_n;
        logic              flag_z;
        logic              flag_v;
        logic              flag_c;
    } rsp_t;

    typedef struct packed {
        logic n;
        logic z;
        logic v;
        logic c;
    } flags_t;

    typedef struct packed {
        logic                  valid;
        logic [REG_ADDR_W-1:0] rd;
        logic [REG_ADDR_W-1:0] rb;
        logic [1:0]            size;
        logic                  sign;
        logic                  postinc;
    } pend_t;

    typedef struct packed {
        logic                  en;
        logic [REG_ADDR_W-1:0] addr;
        logic [DATA_W-1:0]     data;
    } wr_t;

    // reserved size code behaves as word
    function automatic logic [1:0] norm_size(input logic [1:0] code);
        logic [1:0] r;
        r = (code == SIZE_RSVD) ? SIZE_WORD : code;
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] size_bytes(input logic [1:0] code);
        logic [DATA_W-1:0] r;
        unique case (code)
            SIZE_BYTE: r = DATA_W'(1);
            SIZE_HALF: r = DATA_W'(2);
            default:   r = DATA_W'(4);
        endcase
        return r;
    endfunction

endpackage

[design/load_store_alu_execute_unit.sv]
// load_store_alu_execute_unit: top level, request register, execute, response register
// depends on lsae_pkg, lsae_regfile, lsae_exec
//
//   channel  direction  handshake             beat
//   req      in         req_valid/req_stall   lsae_pkg::req_t
//   rsp      out        rsp_valid/rsp_stall   lsae_pkg::rsp_t
//
// one beat per cycle unless rsp stalls; rsp valid once the beat moves into the response register
// the request register feeds the alu and register file, the response register holds the result
// registers, flags and pending load are updated when a beat moves into the response register
// req_stall rises only while the request register is full and a held response is stalled
// reset clears the valid bits, the general registers, the flags and the pending load

module load_store_alu_execute_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  lsae_pkg::req_t   req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output lsae_pkg::rsp_t   rsp
);
    import lsae_pkg::*;

    logic    s1_valid_reg;
    logic    s1_valid_next;
    req_t    s1_reg;
    logic    rsp_valid_reg;
    logic    rsp_valid_next;
    rsp_t    rsp_reg;
    flags_t  flags_reg;
    pend_t   pend_reg;
    logic    advance;
    logic    take;

    rsp_t              ex_rsp;
    flags_t            ex_flags;
    pend_t             ex_pend;
    wr_t               ex_wr_a;
    wr_t               ex_wr_b;
    wr_t               wr_a;
    wr_t               wr_b;
    logic [DATA_W-1:0] rd_val;
    logic [DATA_W-1:0] rs_val;
    logic [DATA_W-1:0] rb_val;

    assign advance   = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && !advance;
    assign take      = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign s1_valid_next  = take ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign rsp_valid_next = advance ? 1'b1 : (rsp_stall ? rsp_valid_reg : 1'b0);

    always_comb
    begin
        wr_a    = ex_wr_a;
        wr_b    = ex_wr_b;
        wr_a.en = ex_wr_a.en & advance;
        wr_b.en = ex_wr_b.en & advance;
    end

    lsae_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .raddr_a (s1_reg.dest_reg),
        .raddr_b (s1_reg.src_reg),
        .raddr_c (pend_reg.rb),
        .rdata_a (rd_val),
        .rdata_b (rs_val),
        .rdata_c (rb_val),
        .wr_a    (wr_a),
        .wr_b    (wr_b)
    );

    lsae_exec u_exec (
        .req        (s1_reg),
        .flags      (flags_reg),
        .pend       (pend_reg),
        .rd_val     (rd_val),
        .rs_val     (rs_val),
        .rb_val     (rb_val),
        .rsp        (ex_rsp),
        .flags_next (ex_flags),
        .pend_next  (ex_pend),
        .wr_a       (ex_wr_a),
        .wr_b       (ex_wr_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            flags_reg     <= '0;
            pend_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (advance)
            begin
                flags_reg <= ex_flags;
                pend_reg  <= ex_pend;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_reg <= req;
        end
        if (advance)
        begin
            rsp_reg <= ex_rsp;
        end
    end

    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> s1_valid_reg && rsp_valid_reg)
        else $error("request stalled without a full pipeline");

    a_advance_fills_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp_valid_reg)
        else $error("executed beat did not reach the response register");

    a_write_is_request: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.bus_write |-> rsp_reg.bus_request)
        else $error("bus write without bus request");

    a_idle_bus_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp_reg.bus_request |->
            rsp_reg.bus_address == '0 && rsp_reg.bus_write_data == '0)
        else $error("bus fields nonzero without a request");

    a_return_clears_pend: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_reg.req_type == OP_LOAD_RETURN |=> !pend_reg.valid)
        else $error("pending load survived its return");

endmodule

[design/lsae_regfile.sv]
// lsae_regfile: sixteen 32-bit general registers, three read ports, two write ports
// depends on lsae_pkg; port b wins when both write the same register

module lsae_regfile (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [lsae_pkg::REG_ADDR_W-1:0] raddr_a,
    input  logic [lsae_pkg::REG_ADDR_W-1:0] raddr_b,
    input  logic [lsae_pkg::REG_ADDR_W-1:0] raddr_c,
    output logic [lsae_pkg::DATA_W-1:0]     rdata_a,
    output logic [lsae_pkg::DATA_W-1:0]     rdata_b,
    output logic [lsae_pkg::DATA_W-1:0]     rdata_c,
    input  lsae_pkg::wr_t                   wr_a,
    input  lsae_pkg::wr_t                   wr_b
);
    import lsae_pkg::*;

    logic [DATA_W-1:0] regs_reg [REG_COUNT];

    assign rdata_a = regs_reg[raddr_a];
    assign rdata_b = regs_reg[raddr_b];
    assign rdata_c = regs_reg[raddr_c];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                regs_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                if (wr_b.en && wr_b.addr == REG_ADDR_W'(i))
                begin
                    regs_reg[i] <= wr_b.data;
                end
                else if (wr_a.en && wr_a.addr == REG_ADDR_W'(i))
                begin
                    regs_reg[i] <= wr_a.data;
                end
            end
        end
    end

endmodule

[design/lsae_exec.sv]
// lsae_exec: combinational execute of one request (alu, flags, bus issue, load completion)
// depends on lsae_pkg; reads register values and state supplied by the top level

module lsae_exec (
    input  lsae_pkg::req_t              req,
    input  lsae_pkg::flags_t            flags,
    input  lsae_pkg::pend_t             pend,
    input  logic [lsae_pkg::DATA_W-1:0] rd_val,
    input  logic [lsae_pkg::DATA_W-1:0] rs_val,
    input  logic [lsae_pkg::DATA_W-1:0] rb_val,
    output lsae_pkg::rsp_t              rsp,
    output lsae_pkg::flags_t            flags_next,
    output lsae_pkg::pend_t             pend_next,
    output lsae_pkg::wr_t               wr_a,
    output lsae_pkg::wr_t               wr_b
);
    import lsae_pkg::*;

    logic [DATA_W-1:0] imm;
    logic [DATA_W-1:0] op_a;
    logic [DATA_W-1:0] op_b;
    logic [DATA_W:0]   sum;
    logic [DATA_W-1:0] diff;
    logic [DATA_W-1:0] addr;
    logic [1:0]        sz;
    logic [DATA_W-1:0] ld_val;
    logic [DATA_W-1:0] inc_base;
    logic [DATA_W-1:0] res;

    assign imm  = req.ext_present ? req.ext_imm : '0;
    assign op_a = req.ext_present ? rs_val : rd_val;
    assign op_b = req.ext_present ? req.ext_imm : rs_val;
    assign sum  = {1'b0, op_a} + {1'b0, op_b};
    assign diff = op_a - op_b;
    assign addr = rs_val + imm;
    assign sz   = norm_size(req.access_size);

    always_comb
    begin
        unique case (pend.size)
            SIZE_BYTE: ld_val = {{(DATA_W-8){pend.sign & req.load_data[7]}},
                                 req.load_data[7:0]};
            SIZE_HALF: ld_val = {{(DATA_W-16){pend.sign & req.load_data[15]}},
                                 req.load_data[15:0]};
            default:   ld_val = req.load_data;
        endcase
    end

    // rd == rb: increment applies on top of the loaded value
    assign inc_base = (pend.rb == pend.rd) ? ld_val : rb_val;

    always_comb
    begin
        res        = '0;
        flags_next = flags;
        pend_next  = pend;
        wr_a       = '0;
        wr_b       = '0;
        rsp        = '0;
        unique case (req.req_type)
            OP_ADD:
            begin
                res          = sum[DATA_W-1:0];
                flags_next.v = ~(op_a[DATA_W-1] ^ op_b[DATA_W-1])
                               & (op_a[DATA_W-1] ^ sum[DATA_W-1]);
                flags_next.c = sum[DATA_W];
            end
            OP_SUB, OP_CMP:
            begin
                res          = diff;
                flags_next.v = (op_a[DATA_W-1] ^ op_b[DATA_W-1])
                               & (op_a[DATA_W-1] ^ diff[DATA_W-1]);
                flags_next.c = op_a < op_b;
            end
            OP_MOV: res = rs_val;
            OP_AND: res = op_a & op_b;
            OP_OR:  res = op_a | op_b;
            OP_XOR: res = op_a ^ op_b;
            OP_NOT: res = ~rs_val;
            OP_LOAD:
            begin
                rsp.bus_request   = 1'b1;
                rsp.bus_address   = addr;
                rsp.bus_size      = sz;
                pend_next.valid   = 1'b1;
                pend_next.rd      = req.dest_reg;
                pend_next.rb      = req.src_reg;
                pend_next.size    = sz;
                pend_next.sign    = req.sign_extend;
                pend_next.postinc = req.post_increment;
            end
            OP_STORE:
            begin
                rsp.bus_request = 1'b1;
                rsp.bus_write   = 1'b1;
                rsp.bus_address = addr;
                rsp.bus_size    = sz;
                unique case (sz)
                    SIZE_BYTE: rsp.bus_write_data = {{(DATA_W-8){1'b0}}, rd_val[7:0]};
                    SIZE_HALF: rsp.bus_write_data = {{(DATA_W-16){1'b0}}, rd_val[15:0]};
                    default:   rsp.bus_write_data = rd_val;
                endcase
                wr_a.en   = req.post_increment;
                wr_a.addr = req.src_reg;
                wr_a.data = rs_val + size_bytes(sz);
            end
            OP_LOAD_RETURN:
            begin
                if (pend.valid)
                begin
                    res             = ld_val;
                    wr_a.en         = 1'b1;
                    wr_a.addr       = pend.rd;
                    wr_a.data       = ld_val;
                    wr_b.en         = pend.postinc;
                    wr_b.addr       = pend.rb;
                    wr_b.data       = inc_base + size_bytes(pend.size);
                    pend_next.valid = 1'b0;
                end
            end
            default:
            begin
                res = '0;
            end
        endcase

        unique case (req.req_type)
            OP_ADD, OP_SUB, OP_CMP, OP_AND, OP_OR, OP_XOR, OP_NOT:
            begin
                flags_next.n = res[DATA_W-1];
                flags_next.z = (res == '0);
            end
            default:
            begin
                flags_next.n = flags_next.n;
            end
        endcase

        unique case (req.req_type)
            OP_ADD, OP_SUB, OP_MOV, OP_AND, OP_OR, OP_XOR, OP_NOT:
            begin
                wr_a.en   = 1'b1;
                wr_a.addr = req.dest_reg;
                wr_a.data = res;
            end
            default:
            begin
                wr_a.en = wr_a.en;
            end
        endcase

        rsp.result_value = (req.req_type == OP_CMP) ? '0 : res;
        rsp.flag_n       = flags_next.n;
        rsp.flag_z       = flags_next.z;
        rsp.flag_v       = flags_next.v;
        rsp.flag_c       = flags_next.c;
    end

endmodule

[test/lsae_exec_checker.sv]
// lsae_exec_checker: watches the req and rsp channels of the execute unit, predicts each response
// beat from its own register file, flags and pending load, and compares field by field
// depends on lsae_pkg

module lsae_exec_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_stall,
    input  lsae_pkg::req_t req,
    input  logic           rsp_valid,
    input  logic           rsp_stall,
    input  lsae_pkg::rsp_t rsp,
    output int             fail_count,
    output int             outstanding,
    output int             checked
);
    import lsae_pkg::*;

    logic [DATA_W-1:0] gpr [REG_COUNT];
    flags_t            flags;
    pend_t             pend_ld;
    rsp_t              expected_rsp_q [$];
    rsp_t              oldest_rsp;
    int                mismatches;
    int                rsp_seen;

    assign fail_count  = mismatches;
    assign outstanding = expected_rsp_q.size();
    assign checked     = rsp_seen;

    function automatic rsp_t predict_execute(input req_t r);
        rsp_t              o;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] imm;
        logic [DATA_W-1:0] res;
        logic [DATA_W:0]   sum;
        logic [1:0]        sz;
        o   = '0;
        imm = r.ext_present ? r.ext_imm : '0;
        a   = r.ext_present ? gpr[r.src_reg] : gpr[r.dest_reg];
        b   = r.ext_present ? imm : gpr[r.src_reg];
        sz  = (r.access_size == SIZE_RSVD) ? SIZE_WORD : r.access_size;
        case (r.req_type)
            OP_ADD:
            begin
                sum     = {1'b0, a} + {1'b0, b};
                res     = sum[DATA_W-1:0];
                flags.n = res[DATA_W-1];
                flags.z = (res == '0);
                flags.v = (a[DATA_W-1] == b[DATA_W-1]) && (res[DATA_W-1] != a[DATA_W-1]);
                flags.c = sum[DATA_W];
                gpr[r.dest_reg] = res;
                o.result_value  = res;
            end
            OP_SUB, OP_CMP:
            begin
                res     = a - b;
                flags.n = res[DATA_W-1];
                flags.z = (res == '0);
                flags.v = (a[DATA_W-1] != b[DATA_W-1]) && (res[DATA_W-1] != a[DATA_W-1]);
                flags.c = (a < b);
                if (r.req_type == OP_SUB)
                begin
                    gpr[r.dest_reg] = res;
                    o.result_value  = res;
                end
            end
            OP_MOV:
            begin
                res             = gpr[r.src_reg];
                gpr[r.dest_reg] = res;
                o.result_value  = res;
            end
            OP_AND, OP_OR, OP_XOR, OP_NOT:
            begin
                if (r.req_type == OP_AND)
                    res = a & b;
                else if (r.req_type == OP_OR)
                    res = a | b;
                else if (r.req_type == OP_XOR)
                    res = a ^ b;
                else
                    res = ~gpr[r.src_reg];
                flags.n         = res[DATA_W-1];
                flags.z         = (res == '0);
                gpr[r.dest_reg] = res;
                o.result_value  = res;
            end
            OP_LOAD:
            begin
                o.bus_request   = 1'b1;
                o.bus_address   = gpr[r.src_reg] + imm;
                o.bus_size      = sz;
                pend_ld.valid   = 1'b1;
                pend_ld.rd      = r.dest_reg;
                pend_ld.rb      = r.src_reg;
                pend_ld.size    = sz;
                pend_ld.sign    = r.sign_extend;
                pend_ld.postinc = r.post_increment;
            end
            OP_STORE:
            begin
                // data is taken before any post-increment of the base
                res           = gpr[r.dest_reg];
                o.bus_request = 1'b1;
                o.bus_write   = 1'b1;
                o.bus_address = gpr[r.src_reg] + imm;
                o.bus_size    = sz;
                if (sz == SIZE_BYTE)
                    o.bus_write_data = {24'b0, res[7:0]};
                else if (sz == SIZE_HALF)
                    o.bus_write_data = {16'b0, res[15:0]};
                else
                    o.bus_write_data = res;
                if (r.post_increment)
                    gpr[r.src_reg] = gpr[r.src_reg] + (32'd1 << sz);
            end
            OP_LOAD_RETURN:
            begin
                if (pend_ld.valid)
                begin
                    if (pend_ld.size == SIZE_BYTE)
                        res = {{24{pend_ld.sign & r.load_data[7]}}, r.load_data[7:0]};
                    else if (pend_ld.size == SIZE_HALF)
                        res = {{16{pend_ld.sign & r.load_data[15]}}, r.load_data[15:0]};
                    else
                        res = r.load_data;
                    gpr[pend_ld.rd] = res;
                    o.result_value  = res;
                    // base update lands after the destination write
                    if (pend_ld.postinc)
                        gpr[pend_ld.rb] = gpr[pend_ld.rb] + (32'd1 << pend_ld.size);
                    pend_ld.valid = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        o.flag_n = flags.n;
        o.flag_z = flags.z;
        o.flag_v = flags.v;
        o.flag_c = flags.c;
        return o;
    endfunction

    task automatic compare_field(input string name, input logic [DATA_W-1:0] exp_v,
                                 input logic [DATA_W-1:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s expected %0h actual %0h", name, exp_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
                gpr[i] = '0;
            flags      = '0;
            pend_ld    = '0;
            mismatches = 0;
            rsp_seen   = 0;
            expected_rsp_q.delete();
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    $error("rsp beat with no expected response");
                    mismatches++;
                end
                else
                begin
                    oldest_rsp = expected_rsp_q.pop_front();
                    compare_field("bus_request", oldest_rsp.bus_request, rsp.bus_request);
                    compare_field("bus_write", oldest_rsp.bus_write, rsp.bus_write);
                    compare_field("bus_address", oldest_rsp.bus_address, rsp.bus_address);
                    compare_field("bus_size", oldest_rsp.bus_size, rsp.bus_size);
                    compare_field("bus_write_data", oldest_rsp.bus_write_data,
                                  rsp.bus_write_data);
                    compare_field("result_value", oldest_rsp.result_value, rsp.result_value);
                    compare_field("flag_n", oldest_rsp.flag_n, rsp.flag_n);
                    compare_field("flag_z", oldest_rsp.flag_z, rsp.flag_z);
                    compare_field("flag_v", oldest_rsp.flag_v, rsp.flag_v);
                    compare_field("flag_c", oldest_rsp.flag_c, rsp.flag_c);
                    rsp_seen++;
                end
            end
            if (req_valid && !req_stall)
                expected_rsp_q.push_back(predict_execute(req));
        end
    end

endmodule

[test/tb_top.sv]
// tb_top: stimulus, stall patterns and verdict for load_store_alu_execute_unit
// depends on lsae_pkg, load_store_alu_execute_unit and lsae_exec_checker

module tb_top;
    import lsae_pkg::*;

    localparam int         IDLE_LIMIT  = 1000;
    localparam int         HOLD_CYCLES = 60;
    localparam int         PHASE_ITEMS = 360;
    localparam int         BURST_ITEMS = 32;
    localparam logic [3:0] OP_UNDEF_LO = 4'd11;
    localparam logic [3:0] OP_UNDEF_HI = 4'd15;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    int   fail_count;
    int   outstanding;
    int   checked;
    int   send_idle_pct = 0;
    int   rcv_stall_pct = 0;
    logic hold_tog      = 1'b0;
    logic hold_seen     = 1'b0;
    int   hold_left     = 0;
    int   idle_run      = 0;
    int   beats_sent    = 0;
    int   loads_sent    = 0;
    int   stores_sent   = 0;
    bit   return_due    = 1'b0;

    load_store_alu_execute_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    lsae_exec_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .checked     (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // output side: random stalls, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_tog != hold_seen)
        begin
            hold_seen = hold_tog;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left--;
        end
        else
            rsp_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_run = 0;
        else
            idle_run++;
        if (idle_run >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic req_t mk_req(input logic [3:0] op, input logic [REG_ADDR_W-1:0] rd,
                                    input logic [REG_ADDR_W-1:0] rs, input logic ext,
                                    input logic [DATA_W-1:0] imm, input logic [1:0] sz,
                                    input logic sx, input logic pinc,
                                    input logic [DATA_W-1:0] ldata);
        req_t r;
        r.req_type       = op;
        r.dest_reg       = rd;
        r.src_reg        = rs;
        r.ext_present    = ext;
        r.ext_imm        = imm;
        r.access_size    = sz;
        r.sign_extend    = sx;
        r.post_increment = pinc;
        r.load_data      = ldata;
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return 32'h8000_0000;
            3:       return 32'h7fff_ffff;
            4:       return 32'($urandom_range(0, 16));
            default: return $urandom;
        endcase
    endfunction

    function automatic req_t rand_req(input logic [3:0] op);
        return mk_req(op, 4'($urandom), 4'($urandom), 1'($urandom), rand_word(),
                      2'($urandom), 1'($urandom), 1'($urandom), rand_word());
    endfunction

    task automatic drive_beat(input req_t it);
        bit taken;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        req_valid <= 1'b1;
        req       <= it;
        do
        begin
            @(negedge clk);
            taken = !req_stall;
            @(posedge clk);
        end
        while (!taken);
        beats_sent++;
        if (it.req_type == OP_LOAD)
            loads_sent++;
        if (it.req_type == OP_STORE)
            stores_sent++;
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // alu work as the largest share, with loads usually followed by their return beat, and stores and noise around them
    task automatic run_random(input int count);
        logic [3:0] op;
        int         pick;
        repeat (count)
        begin
            if (return_due && $urandom_range(0, 99) < 85)
                op = OP_LOAD_RETURN;
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 48)
                    op = 4'($urandom_range(OP_NOT, OP_ADD));
                else if (pick < 62)
                    op = OP_STORE;
                else if (pick < 84)
                    op = OP_LOAD;
                else if (pick < 92)
                    op = OP_LOAD_RETURN;
                else
                    op = 4'($urandom_range(OP_UNDEF_HI, OP_UNDEF_LO));
            end
            return_due = (op == OP_LOAD);
            drive_beat(rand_req(op));
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // alu extremes and flag corners
        drive_beat(mk_req(OP_ADD, 1, 0, 1, 32'hffff_ffff, SIZE_BYTE, 0, 0, 0));
        drive_beat(mk_req(OP_ADD, 2, 1, 1, 32'h0000_0001, SIZE_BYTE, 0, 0, 0));
        drive_beat(mk_req(OP_ADD, 3, 0, 1, 32'h7fff_ffff, SIZE_BYTE, 0, 0, 0));
        drive_beat(mk_req(OP_ADD, 4, 3, 1, 32'h0000_0001, SIZE_BYTE, 0, 0, 0));
        drive_beat(mk_req(OP_SUB, 4, 3, 0, 32'h1234_5678, SIZE_BYTE, 0, 0, 0));
        drive_beat(mk_req(OP_CMP, 0, 15, 1, 32'h0000_0001, SIZE_BYTE, 0, 0, 0));
        drive_beat(mk_req(OP_MOV, 15, 1, 1, 32'hdead_beef, SIZE_BYTE, 0, 0, 0));
        drive_beat(mk_req(OP_AND, 15, 3, 0, 32'h0000_0000, SIZE_BYTE, 0, 0, 0));
        drive_beat(mk_req(OP_OR, 5, 4, 1, 32'h8000_0000, SIZE_BYTE, 0, 0, 0));
        drive_beat(mk_req(OP_XOR, 5, 1, 0, 32'hffff_ffff, SIZE_BYTE, 0, 0, 0));
        drive_beat(mk_req(OP_NOT, 6, 0, 1, 32'h0000_0055, SIZE_BYTE, 0, 0, 0));
        drive_beat(mk_req(OP_UNDEF_LO, 7, 7, 1, 32'hffff_ffff, SIZE_WORD, 1, 1, 0));
        drive_beat(mk_req(OP_UNDEF_HI, 15, 15, 1, 32'hffff_ffff, SIZE_RSVD, 1, 1, 0));
        // return with nothing pending
        drive_beat(mk_req(OP_LOAD_RETURN, 1, 1, 0, 0, SIZE_WORD, 1, 1, 32'hffff_ffff));
        // signed byte load with base update
        drive_beat(mk_req(OP_LOAD, 7, 3, 1, 32'h0000_0001, SIZE_BYTE, 1, 1, 0));
        drive_beat(mk_req(OP_LOAD_RETURN, 0, 0, 0, 0, SIZE_BYTE, 0, 0, 32'h0000_0080));
        // second load replaces the first; word load ignores sign extension
        drive_beat(mk_req(OP_LOAD, 8, 2, 0, 32'h0000_0100, SIZE_HALF, 0, 0, 0));
        drive_beat(mk_req(OP_LOAD, 9, 0, 1, 32'h0000_0000, SIZE_WORD, 1, 1, 0));
        drive_beat(mk_req(OP_LOAD_RETURN, 0, 0, 0, 0, SIZE_BYTE, 0, 0, 32'hffff_8000));
        // reserved size as word, destination equal to base with update
        drive_beat(mk_req(OP_LOAD, 10, 10, 0, 32'h0000_0000, SIZE_RSVD, 1, 1, 0));
        drive_beat(mk_req(OP_LOAD_RETURN, 0, 0, 0, 0, SIZE_BYTE, 0, 0, 32'h1234_5678));
        drive_beat(mk_req(OP_LOAD, 11, 0, 1, 32'hffff_fffc, SIZE_HALF, 1, 0, 0));
        drive_beat(mk_req(OP_LOAD_RETURN, 0, 0, 0, 0, SIZE_BYTE, 0, 0, 32'h0000_f00f));
        // stores: source equal to base with update, reserved size, halfword
        drive_beat(mk_req(OP_STORE, 1, 1, 1, 32'h0000_0000, SIZE_BYTE, 0, 1, 0));
        drive_beat(mk_req(OP_STORE, 4, 15, 0, 32'h0000_0000, SIZE_RSVD, 0, 1, 0));
        drive_beat(mk_req(OP_STORE, 9, 0, 1, 32'hffff_ffff, SIZE_HALF, 1, 0, 0));
        drain();

        send_idle_pct = 27;
        rcv_stall_pct = 82;
        run_random(PHASE_ITEMS);
        drain();

        send_idle_pct = 82;
        rcv_stall_pct = 27;
        run_random(PHASE_ITEMS);
        drain();

        // long output hold-off while the input keeps offering beats
        send_idle_pct = 0;
        rcv_stall_pct = 0;
        hold_tog      = ~hold_tog;
        run_random(BURST_ITEMS);
        drain();
        run_random(PHASE_ITEMS);
        drain();

        repeat (8) @(posedge clk);
        $display("%0d request beats driven (%0d loads, %0d stores), %0d responses checked",
                 beats_sent, loads_sent, stores_sent, checked);
        $display("stall mixes: input-heavy, output-heavy, none, plus one long output hold-off");
        if (fail_count == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
